// File: rtl/pht_pkg.sv
`timescale 1ns / 1ps
// pht_pkg: table geometry, hash constant and request/status codes of the pid hash set tracker
// no dependencies; used by pid_hash_set_tracker_unit

package pht_pkg;

  // table geometry; the bucket count must be a power of two (bucket = low hash bits)
  localparam int unsigned TABLE_BUCKETS = 64;
  localparam int unsigned BUCKET_WAYS   = 4;
  localparam int unsigned SLOT_COUNT    = TABLE_BUCKETS * BUCKET_WAYS;

  localparam int unsigned BKT_W  = (TABLE_BUCKETS > 1) ? $clog2(TABLE_BUCKETS) : 1;
  localparam int unsigned WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // field widths
  localparam int unsigned PID_W = 22;
  localparam int unsigned REC_W = 32;

  // multiplicative hash constant
  localparam logic [31:0] GOLDEN32 = 32'h61C8_8647;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

// File: rtl/pid_hash_set_tracker_unit.sv
`timescale 1ns / 1ps
// pid_hash_set_tracker_unit: hashed pid set in fixed bucket ways with a record counter
// depends on pht_pkg (geometry, hash constant, command and status codes)

// Each request (lookup, add or delete of a pid) goes from acceptance to a result in the
// output register through the read, compare and exec states, and no new request is
// accepted before the sequencer has returned to idle. The bucket index is taken from
// the low bits of pid * 0x61C88647 in the acceptance cycle; then a small sequencer walks
// the bucket's ways through the single read port of the pid memory, each way in a read
// state (address) and a compare state (registered read data into the shared compare),
// and a final exec state updates the valid bits, the pid memory and the record counter.
// That exec state waits while the previous result is still held in the output register
// and not taken. The unit takes one request at a time; a new request can be accepted
// while the previous result still waits in the output register. The pid memory has no
// reset; valid bits clear on reset, so no clearing pass is needed.

module pid_hash_set_tracker_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic [pht_pkg::PID_W-1:0] pid_i,
  input  logic [pht_pkg::PID_W-1:0] caller_tgid_i,
  input  logic [pht_pkg::PID_W-1:0] caller_pid_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [pht_pkg::REC_W-1:0] hit_count_o,
  output logic [pht_pkg::PID_W-1:0] record_pid_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_EXEC
  } state_e;

  localparam logic [pht_pkg::WAY_W-1:0] LAST_WAY = pht_pkg::WAY_W'(pht_pkg::BUCKET_WAYS - 1);

  // slot address of a way within a bucket
  function automatic logic [pht_pkg::SLOT_W-1:0] slot_addr(
    input logic [pht_pkg::BKT_W-1:0] bkt,
    input logic [pht_pkg::WAY_W-1:0] way
  );
    logic [pht_pkg::SLOT_W-1:0] base;
    base = pht_pkg::SLOT_W'(bkt) * pht_pkg::SLOT_W'(pht_pkg::BUCKET_WAYS);
    return base + pht_pkg::SLOT_W'(way);
  endfunction

  state_e                      state_q, state_d;
  logic [1:0]                  cmd_q, cmd_d;
  logic [pht_pkg::PID_W-1:0]   pid_q, pid_d;
  logic [pht_pkg::PID_W-1:0]   tgid_q, tgid_d;
  logic [pht_pkg::PID_W-1:0]   cpid_q, cpid_d;
  logic [pht_pkg::BKT_W-1:0]   bucket_q, bucket_d;
  logic [pht_pkg::WAY_W-1:0]   way_q, way_d;
  logic                        found_q, found_d;
  logic [pht_pkg::WAY_W-1:0]   found_way_q, found_way_d;
  logic                        free_found_q, free_found_d;
  logic [pht_pkg::WAY_W-1:0]   free_way_q, free_way_d;
  logic [pht_pkg::SLOT_COUNT-1:0] slot_valid_q, slot_valid_d;
  logic [pht_pkg::REC_W-1:0]   counter_q, counter_d;
  logic                        out_valid_q, out_valid_d;
  logic [1:0]                  status_q, status_d;
  logic [pht_pkg::REC_W-1:0]   rec_id_q, rec_id_d;
  logic [pht_pkg::PID_W-1:0]   rec_pid_q, rec_pid_d;

  logic [31:0]                 hash;
  logic [pht_pkg::SLOT_W-1:0]  rd_addr;
  logic [pht_pkg::SLOT_W-1:0]  wr_addr;
  logic                        mem_we;
  logic [pht_pkg::PID_W-1:0]   rdata_q;
  logic                        way_match;
  logic                        exec_go;
  logic [pht_pkg::PID_W-1:0]   slot_mem [pht_pkg::SLOT_COUNT];

  // multiplicative hash of the incoming pid
  assign hash    = 32'(pid_i) * pht_pkg::GOLDEN32;
  assign rd_addr = slot_addr(bucket_q, way_q);
  assign wr_addr = slot_addr(bucket_q, free_way_q);

  // shared way compare: only a valid slot's pid is ever looked at
  assign way_match = slot_valid_q[rd_addr] && (rdata_q == pid_q);
  assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  // sequencer and request execution
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pid_d        = pid_q;
    tgid_d       = tgid_q;
    cpid_d       = cpid_q;
    bucket_d     = bucket_q;
    way_d        = way_q;
    found_d      = found_q;
    found_way_d  = found_way_q;
    free_found_d = free_found_q;
    free_way_d   = free_way_q;
    slot_valid_d = slot_valid_q;
    counter_d    = counter_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    rec_id_d     = rec_id_q;
    rec_pid_d    = rec_pid_q;
    mem_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_i;
          pid_d        = pid_i;
          tgid_d       = caller_tgid_i;
          cpid_d       = caller_pid_i;
          bucket_d     = hash[pht_pkg::BKT_W-1:0];
          way_d        = '0;
          found_d      = 1'b0;
          found_way_d  = '0;
          free_found_d = 1'b0;
          free_way_d   = '0;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        // first matching way and lowest free way
        if (way_match && !found_q) begin
          found_d     = 1'b1;
          found_way_d = way_q;
        end
        if (!slot_valid_q[rd_addr] && !free_found_q) begin
          free_found_d = 1'b1;
          free_way_d   = way_q;
        end
        if (way_q == LAST_WAY) begin
          state_d = S_EXEC;
        end else begin
          way_d   = way_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          status_d    = pht_pkg::ST_NOT_FOUND;
          rec_id_d    = '0;
          rec_pid_d   = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (cmd_q)
            pht_pkg::CMD_LOOKUP: begin
              if (found_q && (tgid_q == pid_q)) begin
                counter_d = counter_q + 1'b1;
                status_d  = pht_pkg::ST_OK;
                rec_id_d  = counter_q + 1'b1;
                rec_pid_d = cpid_q;
              end
            end
            pht_pkg::CMD_ADD: begin
              counter_d = '0;
              if (found_q) begin
                status_d = pht_pkg::ST_PRESENT;
              end else if (free_found_q) begin
                slot_valid_d[wr_addr] = 1'b1;
                mem_we                = 1'b1;
                status_d              = pht_pkg::ST_OK;
              end else begin
                status_d = pht_pkg::ST_FULL;
              end
            end
            pht_pkg::CMD_DELETE: begin
              if (found_q) begin
                slot_valid_d[slot_addr(bucket_q, found_way_q)] = 1'b0;
                status_d = pht_pkg::ST_OK;
              end
            end
            default: begin
              status_d = pht_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, valid bits, counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      pid_q        <= '0;
      tgid_q       <= '0;
      cpid_q       <= '0;
      bucket_q     <= '0;
      way_q        <= '0;
      found_q      <= 1'b0;
      found_way_q  <= '0;
      free_found_q <= 1'b0;
      free_way_q   <= '0;
      slot_valid_q <= '0;
      counter_q    <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      rec_id_q     <= '0;
      rec_pid_q    <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      pid_q        <= pid_d;
      tgid_q       <= tgid_d;
      cpid_q       <= cpid_d;
      bucket_q     <= bucket_d;
      way_q        <= way_d;
      found_q      <= found_d;
      found_way_q  <= found_way_d;
      free_found_q <= free_found_d;
      free_way_q   <= free_way_d;
      slot_valid_q <= slot_valid_d;
      counter_q    <= counter_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      rec_id_q     <= rec_id_d;
      rec_pid_q    <= rec_pid_d;
    end
  end

  // pid memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= pid_q;
    end
    if (state_q == S_READ) begin
      rdata_q <= slot_mem[rd_addr];
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign hit_count_o  = rec_id_q;
  assign record_pid_o = rec_pid_q;

  // an insert only ever lands in a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !slot_valid_q[wr_addr])
    else $error("insert into an occupied slot");

  // the matching way and the chosen free way can never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && free_found_q) |-> (found_way_q != free_way_q))
    else $error("matching way also marked free");

  // a nonzero hit count is only reported with a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rec_id_q != '0)) |-> (status_q == pht_pkg::ST_OK))
    else $error("hit count on a result that is not a hit");

endmodule

// File: test/pid_hash_set_tracker_unit_test.sv
`timescale 1ns / 1ps
// pid_hash_set_tracker_unit_test: self-checking bench for the hashed pid set tracker
// depends on pht_pkg and pid_hash_set_tracker_unit; predicts every result in-bench

module pid_hash_set_tracker_unit_test;

  localparam int unsigned PID_TOP     = (1 << pht_pkg::PID_W) - 1;
  localparam int unsigned RAND_ITEMS  = 620;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 30;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef struct packed {
    pht_pkg::cmd_e             cmd;
    logic [pht_pkg::PID_W-1:0] pid;
    logic [pht_pkg::PID_W-1:0] tgid;
    logic [pht_pkg::PID_W-1:0] cpid;
  } pid_req_t;

  typedef struct packed {
    pht_pkg::status_e          status;
    logic [pht_pkg::REC_W-1:0] rid;
    logic [pht_pkg::PID_W-1:0] rpid;
  } pid_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                cmd_i         = '0;
  logic [pht_pkg::PID_W-1:0] pid_i         = '0;
  logic [pht_pkg::PID_W-1:0] caller_tgid_i = '0;
  logic [pht_pkg::PID_W-1:0] caller_pid_i  = '0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic [1:0]                status_o;
  logic [pht_pkg::REC_W-1:0] hit_count_o;
  logic [pht_pkg::PID_W-1:0] record_pid_o;

  pid_hash_set_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .pid_i         (pid_i),
    .caller_tgid_i (caller_tgid_i),
    .caller_pid_i  (caller_pid_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .hit_count_o   (hit_count_o),
    .record_pid_o  (record_pid_o)
  );

  // shadow copy of the table and the record counter
  logic [pht_pkg::PID_W-1:0] shadow_pid   [pht_pkg::SLOT_COUNT];
  logic                      shadow_valid [pht_pkg::SLOT_COUNT];
  logic [pht_pkg::REC_W-1:0] shadow_count;

  pid_req_t    request_q [$];
  pid_result_t result_q  [$];
  int          item_total   = 0;
  int          req_issued   = 0;
  int          req_accepted = 0;
  int          fail_count   = 0;
  int          cycle_count  = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned bucket_of(logic [pht_pkg::PID_W-1:0] pid);
    logic [31:0] prod;
    prod = 32'(pid) * pht_pkg::GOLDEN32;
    return prod % pht_pkg::TABLE_BUCKETS;
  endfunction

  function automatic logic [pht_pkg::PID_W-1:0] pid_in_bucket(int unsigned bkt);
    logic [pht_pkg::PID_W-1:0] p;
    p = pht_pkg::PID_W'($urandom_range(1, PID_TOP));
    while (bucket_of(p) != bkt) p = pht_pkg::PID_W'($urandom_range(1, PID_TOP));
    return p;
  endfunction

  // expected result of one request; updates the shadow table
  function automatic pid_result_t track_request(pid_req_t r);
    int unsigned base;
    int          hit_way;
    int          free_way;
    pid_result_t res;
    base     = bucket_of(r.pid) * pht_pkg::BUCKET_WAYS;
    hit_way  = -1;
    free_way = -1;
    res      = '{status: pht_pkg::ST_NOT_FOUND, rid: '0, rpid: '0};
    for (int w = 0; w < pht_pkg::BUCKET_WAYS; w++) begin
      if (shadow_valid[base + w] && shadow_pid[base + w] == r.pid && hit_way < 0) hit_way = w;
      if (!shadow_valid[base + w] && free_way < 0) free_way = w;
    end
    case (r.cmd)
      pht_pkg::CMD_LOOKUP: begin
        if (hit_way >= 0 && r.tgid == r.pid) begin
          shadow_count = shadow_count + 1'b1;
          res.status   = pht_pkg::ST_OK;
          res.rid      = shadow_count;
          res.rpid     = r.cpid;
        end
      end
      pht_pkg::CMD_ADD: begin
        shadow_count = '0;
        if (hit_way >= 0) begin
          res.status = pht_pkg::ST_PRESENT;
        end else if (free_way < 0) begin
          res.status = pht_pkg::ST_FULL;
        end else begin
          shadow_valid[base + free_way] = 1'b1;
          shadow_pid[base + free_way]   = r.pid;
          res.status                    = pht_pkg::ST_OK;
        end
      end
      pht_pkg::CMD_DELETE: begin
        if (hit_way >= 0) begin
          shadow_valid[base + hit_way] = 1'b0;
          res.status                   = pht_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic queue_req(input pht_pkg::cmd_e cmd, input logic [pht_pkg::PID_W-1:0] pid,
                           input logic [pht_pkg::PID_W-1:0] tgid,
                           input logic [pht_pkg::PID_W-1:0] cpid);
    request_q.push_back('{cmd: cmd, pid: pid, tgid: tgid, cpid: cpid});
  endtask

  // idle share in percent per phase: sender busy first, then receiver, then none
  function automatic int phase_of(int n);
    if (n < item_total / 3) return 0;
    if (n < (2 * item_total) / 3) return 1;
    return 2;
  endfunction

  // request driver
  always @(negedge clk_i) begin : req_driver
    pid_req_t r;
    int       idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && req_accepted != req_issued)) begin
      case (phase_of(req_accepted))
        0:       idle_pct = 36;
        1:       idle_pct = 85;
        default: idle_pct = 0;
      endcase
      if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        r = request_q.pop_front();
        cmd_i         <= r.cmd;
        pid_i         <= r.pid;
        caller_tgid_i <= r.tgid;
        caller_pid_i  <= r.cpid;
        in_valid_i    <= 1'b1;
        req_issued++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off in the no-idle phase
  always @(negedge clk_i) begin : rsp_ready
    int idle_pct;
    case (phase_of(req_accepted))
      0:       idle_pct = 85;
      1:       idle_pct = 36;
      default: idle_pct = 0;
    endcase
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && phase_of(req_accepted) == 2
                 && req_accepted >= (5 * item_total) / 6) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin : monitor
    pid_req_t    r;
    pid_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        r = '{cmd: pht_pkg::cmd_e'(cmd_i), pid: pid_i, tgid: caller_tgid_i,
              cpid: caller_pid_i};
        result_q.push_back(track_request(r));
        req_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = result_q.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
          if (hit_count_o !== want.rid)
            report_mismatch($sformatf("hit_count %0h, want %0h", hit_count_o, want.rid));
          if (record_pid_o !== want.rpid)
            report_mismatch($sformatf("record_pid %0h, want %0h", record_pid_o, want.rpid));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pid_hash_set_tracker_unit_test NOT OK");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [pht_pkg::PID_W-1:0] mate [4];
    logic [pht_pkg::PID_W-1:0] hot_pid [18];
    logic [pht_pkg::PID_W-1:0] p;
    int unsigned               hot_bkt;
    int unsigned               pick;
    pht_pkg::cmd_e             c;

    for (int s = 0; s < pht_pkg::SLOT_COUNT; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_pid[s]   = '0;
    end
    shadow_count = '0;

    // directed: field extremes, hits, misses, duplicate add, full bucket, reuse of a way
    for (int i = 0; i < 4; i++) mate[i] = pid_in_bucket(bucket_of('0));
    queue_req(pht_pkg::CMD_LOOKUP, '0, '0, '0);
    queue_req(pht_pkg::CMD_DELETE, pht_pkg::PID_W'(PID_TOP), '0, '0);
    queue_req(pht_pkg::CMD_ADD, '0, '0, '0);
    queue_req(pht_pkg::CMD_ADD, '0, '0, '0);
    queue_req(pht_pkg::CMD_LOOKUP, '0, '0, pht_pkg::PID_W'(PID_TOP));
    queue_req(pht_pkg::CMD_LOOKUP, '0, '0, 22'h155555);
    queue_req(pht_pkg::CMD_LOOKUP, '0, 22'h1, 22'h2AAAAA);
    queue_req(pht_pkg::CMD_ADD, pht_pkg::PID_W'(PID_TOP), '0, '0);
    queue_req(pht_pkg::CMD_LOOKUP, pht_pkg::PID_W'(PID_TOP), pht_pkg::PID_W'(PID_TOP), '0);
    queue_req(pht_pkg::CMD_UNUSED, '0, '0, pht_pkg::PID_W'(PID_TOP));
    for (int i = 0; i < 4; i++) queue_req(pht_pkg::CMD_ADD, mate[i], mate[i], '0);
    queue_req(pht_pkg::CMD_LOOKUP, mate[3], mate[3], pht_pkg::PID_W'(PID_TOP));
    queue_req(pht_pkg::CMD_DELETE, '0, '0, '0);
    queue_req(pht_pkg::CMD_ADD, mate[3], '0, '0);
    queue_req(pht_pkg::CMD_LOOKUP, mate[3], mate[3], 22'h2AAAAA);
    queue_req(pht_pkg::CMD_DELETE, mate[3], '0, '0);
    queue_req(pht_pkg::CMD_DELETE, mate[3], '0, '0);
    queue_req(pht_pkg::CMD_LOOKUP, mate[1], mate[2], pht_pkg::PID_W'(PID_TOP));
    queue_req(pht_pkg::CMD_DELETE, pht_pkg::PID_W'(PID_TOP), '0, '0);

    // random: mostly pids crowded into three buckets so that buckets fill and drain
    for (int b = 0; b < 3; b++) begin
      hot_bkt = $urandom_range(0, pht_pkg::TABLE_BUCKETS - 1);
      for (int k = 0; k < 6; k++) hot_pid[b * 6 + k] = pid_in_bucket(hot_bkt);
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 5) begin
        queue_req(pht_pkg::cmd_e'($urandom_range(0, 3)),
                  pht_pkg::PID_W'($urandom_range(0, PID_TOP)),
                  pht_pkg::PID_W'($urandom_range(0, PID_TOP)),
                  pht_pkg::PID_W'($urandom_range(0, PID_TOP)));
      end else begin
        p = ($urandom_range(0, 9) == 0) ? pht_pkg::PID_W'($urandom_range(0, PID_TOP))
                                        : hot_pid[$urandom_range(0, 17)];
        pick = $urandom_range(0, 99);
        if (pick < 45)      c = pht_pkg::CMD_LOOKUP;
        else if (pick < 72) c = pht_pkg::CMD_ADD;
        else if (pick < 97) c = pht_pkg::CMD_DELETE;
        else                c = pht_pkg::CMD_UNUSED;
        queue_req(c, p,
                  ($urandom_range(0, 3) != 0) ? p : pht_pkg::PID_W'($urandom_range(0, PID_TOP)),
                  pht_pkg::PID_W'($urandom_range(0, PID_TOP)));
      end
    end
    item_total = request_q.size();

    // reset
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: all requests taken and every result seen
    do @(negedge clk_i);
    while (!(req_accepted == item_total && result_q.size() == 0));
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("pid_hash_set_tracker_unit_test OK");
    end else begin
      $display("pid_hash_set_tracker_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pht_pkg.sv
rtl/pid_hash_set_tracker_unit.sv
test/pid_hash_set_tracker_unit_test.sv
